[hdl/column_glyph_digit_reader_macros.svh]
// assertion helpers, sampled on clk and held off during reset
`ifndef COLUMN_GLYPH_DIGIT_READER_MACROS_SVH
`define COLUMN_GLYPH_DIGIT_READER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CGDR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CGDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cgdr_pkg.sv]
package cgdr_pkg;

    localparam int STRIP_HEIGHT_DEF    = 16;
    localparam int MAX_GLYPH_WIDTH_DEF = 16;

    localparam int PIX_W   = 16;
    localparam int VALUE_W = 31;
    localparam int COUNT_W = 4;
    localparam int CFG_W   = 5;

    localparam logic [VALUE_W-1:0] VALUE_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [CFG_W-1:0]   ROWS_RESET = 5'd16;
    localparam logic [CFG_W-1:0]   MINW_RESET = 5'd4;

    typedef enum logic
    {
        CFG_ROWS_IN_USE     = 1'b0,
        CFG_MIN_GLYPH_WIDTH = 1'b1
    } cfg_index_t;

    localparam logic [3:0] DIGIT_0 = 4'd0;
    localparam logic [3:0] DIGIT_1 = 4'd1;
    localparam logic [3:0] DIGIT_2 = 4'd2;
    localparam logic [3:0] DIGIT_3 = 4'd3;
    localparam logic [3:0] DIGIT_4 = 4'd4;
    localparam logic [3:0] DIGIT_5 = 4'd5;
    localparam logic [3:0] DIGIT_6 = 4'd6;
    localparam logic [3:0] DIGIT_7 = 4'd7;
    localparam logic [3:0] DIGIT_8 = 4'd8;
    localparam logic [3:0] DIGIT_9 = 4'd9;

    typedef struct packed
    {
        logic [PIX_W-1:0] column_pixels;
        logic             last_column;
    } col_t;

    typedef struct packed
    {
        logic [VALUE_W-1:0] number_value;
        logic [COUNT_W-1:0] digit_count;
        logic               overflow_flag;
    } res_t;

    // glyph close event leaving the column stage
    typedef struct packed
    {
        logic close;
        logic wide;
        logic last;
    } close_tok_t;

    // classified glyph leaving the classifier stage
    typedef struct packed
    {
        logic       digit_ok;
        logic       wide;
        logic       last;
        logic [3:0] digit;
    } digit_tok_t;

endpackage

[hdl/cgdr_glyph_track.sv]
module cgdr_glyph_track #(
    parameter int ROW_W = 16,
    parameter int MAX_W = 16,
    parameter int WID_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    col_take,
    input  logic                    p2_free,
    input  logic [ROW_W-1:0]        col_pixels,
    input  logic                    col_last,
    input  logic [WID_W-1:0]        minw_eff,
    output logic                    p1_valid,
    output cgdr_pkg::close_tok_t    p1_tok,
    output logic [WID_W-1:0]        p1_width,
    output logic [ROW_W-1:0]        row_union,
    output logic [ROW_W-1:0]        row_and,
    output logic [ROW_W-1:0]        col0,
    output logic [ROW_W-1:0]        col1,
    output logic [ROW_W-1:0]        col2,
    output logic [ROW_W-1:0]        colmid,
    output logic [ROW_W-1:0]        last0,
    output logic [ROW_W-1:0]        last1,
    output logic [ROW_W-1:0]        last2
);
    import cgdr_pkg::*;

    localparam int IW = $clog2(MAX_W);

    logic [ROW_W-1:0] store_reg [MAX_W];

    logic             in_glyph_reg, in_glyph_next;
    logic [WID_W-1:0] width_reg, width_next;
    logic [ROW_W-1:0] union_reg, union_next;
    logic [ROW_W-1:0] and_reg, and_next;
    logic [ROW_W-1:0] last0_reg, last1_reg, last2_reg;
    logic             p1_valid_reg, p1_valid_next;
    close_tok_t       p1_tok_reg, p1_tok_next;
    logic [WID_W-1:0] p1_width_reg, p1_width_next;

    logic             pix_lit;
    logic [WID_W-1:0] w_cur;
    logic             qualify;
    logic             too_wide;
    logic [WID_W-1:0] mid_full;

    assign pix_lit  = |col_pixels;
    assign w_cur    = in_glyph_reg ? width_reg : '0;
    assign qualify  = (width_reg >= minw_eff);
    assign too_wide = (width_reg > WID_W'(MAX_W));

    always_comb
    begin
        in_glyph_next = in_glyph_reg;
        width_next    = width_reg;
        union_next    = union_reg;
        and_next      = and_reg;
        p1_tok_next   = p1_tok_reg;
        p1_width_next = p1_width_reg;
        p1_valid_next = p2_free ? 1'b0 : p1_valid_reg;
        if (col_take)
        begin
            p1_valid_next     = 1'b1;
            p1_width_next     = width_reg;
            p1_tok_next.close = 1'b0;
            p1_tok_next.wide  = 1'b0;
            p1_tok_next.last  = col_last;
            if (pix_lit)
            begin
                in_glyph_next = 1'b1;
                union_next    = (in_glyph_reg ? union_reg : '0) | col_pixels;
                and_next      = (in_glyph_reg ? and_reg : '1) & col_pixels;
                if (w_cur <= WID_W'(MAX_W))
                begin
                    width_next = w_cur + WID_W'(1);
                end
                else
                begin
                    width_next = w_cur;
                end
            end
            else if (in_glyph_reg)
            begin
                p1_tok_next.close = qualify && !too_wide;
                p1_tok_next.wide  = qualify && too_wide;
                in_glyph_next     = 1'b0;
                width_next        = '0;
            end
            // a glyph still open on the last column is dropped
            if (col_last)
            begin
                in_glyph_next = 1'b0;
                width_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_glyph_reg <= 1'b0;
            width_reg    <= '0;
            union_reg    <= '0;
            and_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            in_glyph_reg <= in_glyph_next;
            width_reg    <= width_next;
            union_reg    <= union_next;
            and_reg      <= and_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_tok_reg   <= p1_tok_next;
        p1_width_reg <= p1_width_next;
        if (col_take && pix_lit)
        begin
            last0_reg <= col_pixels;
            last1_reg <= last0_reg;
            last2_reg <= last1_reg;
            if (w_cur < WID_W'(MAX_W))
            begin
                store_reg[w_cur[IW-1:0]] <= col_pixels;
            end
        end
    end

    assign mid_full = p1_width_reg >> 1;

    assign p1_valid  = p1_valid_reg;
    assign p1_tok    = p1_tok_reg;
    assign p1_width  = p1_width_reg;
    assign row_union = union_reg;
    assign row_and   = and_reg;
    assign col0      = store_reg[0];
    assign col1      = store_reg[1];
    assign col2      = store_reg[2];
    assign colmid    = store_reg[mid_full[IW-1:0]];
    assign last0     = last0_reg;
    assign last1     = last1_reg;
    assign last2     = last2_reg;

endmodule

[hdl/cgdr_classify.sv]
module cgdr_classify #(
    parameter int ROW_W = 16,
    parameter int WID_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    p1_valid,
    input  cgdr_pkg::close_tok_t    p1_tok,
    input  logic [WID_W-1:0]        p1_width,
    input  logic [ROW_W-1:0]        row_union,
    input  logic [ROW_W-1:0]        row_and,
    input  logic [ROW_W-1:0]        col0,
    input  logic [ROW_W-1:0]        col1,
    input  logic [ROW_W-1:0]        col2,
    input  logic [ROW_W-1:0]        colmid,
    input  logic [ROW_W-1:0]        last0,
    input  logic [ROW_W-1:0]        last1,
    input  logic [ROW_W-1:0]        last2,
    input  logic                    p2_free,
    input  logic                    p2_take,
    output logic                    p2_valid,
    output cgdr_pkg::digit_tok_t    p2_tok
);
    import cgdr_pkg::*;

    localparam int EW       = $clog2(ROW_W + 1) + 2;
    localparam int DIV3_MUL = 171;
    localparam int DIV5_MUL = 205;

    logic [EW-1:0]   top_e, bot_e, h_e, half_e, h23_e, h25_e;
    logic [EW+8:0]   p3;
    logic [EW+9:0]   p5;
    logic [ROW_W-1:0] mc, m2, m7, m3, m5, m0, m6, m9;
    logic [ROW_W-1:0] c5;
    logic            w_ge2, w_ge3, h_ge2;
    logic            t1, t2, t7, t4, t3, t5, t0, t6, t9;
    logic [3:0]      digit;

    logic            p2_valid_reg, p2_valid_next;
    digit_tok_t      p2_tok_reg;

    // crop rows from the lit-row union
    always_comb
    begin
        top_e = '0;
        bot_e = '0;
        for (int r = ROW_W - 1; r >= 0; r--)
        begin
            if (row_union[r])
            begin
                top_e = EW'(r);
            end
        end
        for (int r = 0; r < ROW_W; r++)
        begin
            if (row_union[r])
            begin
                bot_e = EW'(r + 1);
            end
        end
    end

    assign h_e    = bot_e - top_e;
    assign half_e = h_e >> 1;
    assign p3     = (EW+9)'({h_e, 1'b0}) * (EW+9)'(DIV3_MUL);
    assign p5     = (EW+10)'({h_e, 1'b0}) * (EW+10)'(DIV5_MUL);
    assign h23_e  = p3[EW+8:9];
    assign h25_e  = p5[EW+9:10];

    always_comb
    begin
        for (int r = 0; r < ROW_W; r++)
        begin
            mc[r] = (EW'(r) >= top_e) && (EW'(r) < bot_e);
            m2[r] = (EW'(r + 2) >= bot_e) && (EW'(r) < bot_e);
            m7[r] = (EW'(r) >= top_e) && (EW'(r) < top_e + EW'(2));
            m3[r] = (EW'(r) >= top_e) && (EW'(r) < top_e + h23_e);
            m5[r] = (EW'(r) >= top_e + half_e) && (EW'(r) < top_e + half_e + EW'(2));
            m0[r] = (EW'(r + 1) >= top_e + half_e) && (EW'(r) <= top_e + half_e + EW'(1));
            m6[r] = (EW'(r) >= top_e) && (EW'(r) < top_e + h25_e);
            m9[r] = (EW'(r + 3) >= bot_e) && (EW'(r) < bot_e);
        end
    end

    assign w_ge2 = (p1_width >= WID_W'(2));
    assign w_ge3 = (p1_width >= WID_W'(3));
    assign h_ge2 = (h_e >= EW'(2));
    assign c5    = col0 | (w_ge2 ? col1 : '0) | (w_ge3 ? col2 : '0);

    // full-height tests need every crop row lit, holes in the union included
    assign t1 = w_ge2 && ((last0 & mc) == mc)
                      && ((last1 & mc) == mc);
    assign t2 = h_ge2 && ((row_and & m2) == m2);
    assign t7 = h_ge2 && ((row_and & m7) == m7);
    assign t4 = w_ge3 && ((last1 & mc) == mc)
                      && ((last2 & mc) == mc);
    assign t3 = ((col0 & m3) == '0);
    assign t5 = ((c5 & m5) == '0);
    assign t0 = ((colmid & m0) == '0);
    assign t6 = ((last0 & m6) == '0);
    assign t9 = ((last0 & m9) == '0);

    always_comb
    begin
        if (t1)
        begin
            digit = DIGIT_1;
        end
        else if (t2)
        begin
            digit = DIGIT_2;
        end
        else if (t7)
        begin
            digit = DIGIT_7;
        end
        else if (t4)
        begin
            digit = DIGIT_4;
        end
        else if (t3)
        begin
            digit = DIGIT_3;
        end
        else if (t5)
        begin
            digit = DIGIT_5;
        end
        else if (t0)
        begin
            digit = DIGIT_0;
        end
        else if (t6)
        begin
            digit = DIGIT_6;
        end
        else if (t9)
        begin
            digit = DIGIT_9;
        end
        else
        begin
            digit = DIGIT_8;
        end
    end

    assign p2_valid_next = (p1_valid && p2_free) ? 1'b1 : (p2_take ? 1'b0 : p2_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= p2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid && p2_free)
        begin
            p2_tok_reg.digit_ok <= p1_tok.close;
            p2_tok_reg.wide     <= p1_tok.wide;
            p2_tok_reg.last     <= p1_tok.last;
            p2_tok_reg.digit    <= digit;
        end
    end

    assign p2_valid = p2_valid_reg;
    assign p2_tok   = p2_tok_reg;

endmodule

[hdl/cgdr_accum.sv]
module cgdr_accum (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 p2_valid,
    input  cgdr_pkg::digit_tok_t p2_tok,
    input  logic                 res_ready,
    output logic                 p2_take,
    output logic                 res_valid,
    output cgdr_pkg::res_t       res_data
);
    import cgdr_pkg::*;

    localparam int SUM_W = VALUE_W + 4;

    logic [VALUE_W-1:0] value_reg, value_next, value_upd;
    logic [COUNT_W-1:0] count_reg, count_next, count_upd;
    logic               ov_reg, ov_next, ov_upd;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;
    logic [SUM_W-1:0]   v_ext, v_sum;

    assign p2_take = p2_valid && (!p2_tok.last || !res_valid_reg || res_ready);

    // value * 10 + digit as two shifts and adds
    assign v_ext = SUM_W'(value_reg);
    assign v_sum = (v_ext << 3) + (v_ext << 1) + SUM_W'(p2_tok.digit);

    always_comb
    begin
        value_upd = value_reg;
        count_upd = count_reg;
        ov_upd    = ov_reg || p2_tok.wide;
        if (p2_tok.digit_ok)
        begin
            if (v_sum > SUM_W'(VALUE_MAX))
            begin
                value_upd = VALUE_MAX;
                ov_upd    = 1'b1;
            end
            else
            begin
                value_upd = v_sum[VALUE_W-1:0];
            end
            if (count_reg != COUNT_MAX)
            begin
                count_upd = count_reg + COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        value_next     = value_reg;
        count_next     = count_reg;
        ov_next        = ov_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (p2_take)
        begin
            if (p2_tok.last)
            begin
                res_next.number_value  = value_upd;
                res_next.digit_count   = count_upd;
                res_next.overflow_flag = ov_upd;
                res_valid_next         = 1'b1;
                value_next             = '0;
                count_next             = '0;
                ov_next                = 1'b0;
            end
            else
            begin
                value_next = value_upd;
                count_next = count_upd;
                ov_next    = ov_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg     <= '0;
            count_reg     <= '0;
            ov_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            value_reg     <= value_next;
            count_reg     <= count_next;
            ov_reg        <= ov_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

[hdl/column_glyph_digit_reader.sv]
// channel   direction  handshake              payload
// col       in         col_valid / col_ready  col_data (column_pixels, last_column)
// res       out        res_valid / res_ready  res_data (number_value, digit_count,
//                                             overflow_flag)
// cfg       in         cfg_wr_en              cfg_index, cfg_data
//
// one column per cycle while col_ready is high; three register stages: column tracking, glyph
// classification, decimal accumulation
// the result comes through the tracking, classification and result registers after the edge that takes the last column
// rst_n clears the strip state and loads rows_in_use 16, min_glyph_width 4
// col_ready drops only when a result waits in the output register and the
// next last column has reached the accumulator
`include "column_glyph_digit_reader_macros.svh"

module column_glyph_digit_reader #(
    parameter int STRIP_HEIGHT    = cgdr_pkg::STRIP_HEIGHT_DEF,
    parameter int MAX_GLYPH_WIDTH = cgdr_pkg::MAX_GLYPH_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       col_valid,
    output logic                       col_ready,
    input  cgdr_pkg::col_t             col_data,
    output logic                       res_valid,
    input  logic                       res_ready,
    output cgdr_pkg::res_t             res_data,
    input  logic                       cfg_wr_en,
    input  cgdr_pkg::cfg_index_t       cfg_index,
    input  logic [cgdr_pkg::CFG_W-1:0] cfg_data
);
    import cgdr_pkg::*;

    localparam int ROW_W = (STRIP_HEIGHT < PIX_W) ? STRIP_HEIGHT : PIX_W;
    localparam int WID_W = $clog2(MAX_GLYPH_WIDTH + 2);

    logic [CFG_W-1:0] rows_reg, minw_reg;
    logic [ROW_W-1:0] row_mask;
    logic [ROW_W-1:0] col_masked;
    logic [WID_W-1:0] minw_eff;
    logic             col_take;

    logic             p1_valid;
    close_tok_t       p1_tok;
    logic [WID_W-1:0] p1_width;
    logic [ROW_W-1:0] row_union, row_and;
    logic [ROW_W-1:0] col0, col1, col2, colmid, last0, last1, last2;
    logic             p2_valid, p2_take, p2_free;
    digit_tok_t       p2_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            minw_reg <= MINW_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ROWS_IN_USE:     rows_reg <= cfg_data;
                CFG_MIN_GLYPH_WIDTH: minw_reg <= cfg_data;
            endcase
        end
    end

    // at least three rows are always in use
    always_comb
    begin
        for (int r = 0; r < ROW_W; r++)
        begin
            row_mask[r] = (r < 3) || (int'(rows_reg) > r);
        end
    end

    always_comb
    begin
        if (minw_reg == '0)
        begin
            minw_eff = WID_W'(1);
        end
        else if (int'(minw_reg) > MAX_GLYPH_WIDTH + 1)
        begin
            minw_eff = WID_W'(MAX_GLYPH_WIDTH + 1);
        end
        else
        begin
            minw_eff = WID_W'(minw_reg);
        end
    end

    assign col_masked = col_data.column_pixels[ROW_W-1:0] & row_mask;
    assign p2_free    = !p2_valid || p2_take;
    assign col_ready  = !p1_valid || p2_free;
    assign col_take   = col_valid && col_ready;

    cgdr_glyph_track #(
        .ROW_W (ROW_W),
        .MAX_W (MAX_GLYPH_WIDTH),
        .WID_W (WID_W)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .col_take   (col_take),
        .p2_free    (p2_free),
        .col_pixels (col_masked),
        .col_last   (col_data.last_column),
        .minw_eff   (minw_eff),
        .p1_valid   (p1_valid),
        .p1_tok     (p1_tok),
        .p1_width   (p1_width),
        .row_union  (row_union),
        .row_and    (row_and),
        .col0       (col0),
        .col1       (col1),
        .col2       (col2),
        .colmid     (colmid),
        .last0      (last0),
        .last1      (last1),
        .last2      (last2)
    );

    cgdr_classify #(
        .ROW_W (ROW_W),
        .WID_W (WID_W)
    ) u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .p1_valid  (p1_valid),
        .p1_tok    (p1_tok),
        .p1_width  (p1_width),
        .row_union (row_union),
        .row_and   (row_and),
        .col0      (col0),
        .col1      (col1),
        .col2      (col2),
        .colmid    (colmid),
        .last0     (last0),
        .last1     (last1),
        .last2     (last2),
        .p2_free   (p2_free),
        .p2_take   (p2_take),
        .p2_valid  (p2_valid),
        .p2_tok    (p2_tok)
    );

    cgdr_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .p2_valid  (p2_valid),
        .p2_tok    (p2_tok),
        .res_ready (res_ready),
        .p2_take   (p2_take),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    `CGDR_ASSERT_IMPL(a_stall_needs_token, !col_ready, p1_valid && p2_valid,
        "column input stalled with an empty pipeline")
    `CGDR_ASSERT_IMPL(a_res_from_last, $rose(res_valid), $past(p2_take && p2_tok.last),
        "result raised without a last column leaving the accumulator")
    `CGDR_ASSERT_IMPL(a_last_held, p2_valid && p2_tok.last && !p2_take,
        res_valid && !res_ready, "last column held while output is free")

endmodule
